/* rtl/bitmap_to_lcd_page_transpose_core_macros.svh */
// Assertion macros for the bitmap to LCD page transpose core.
// No dependencies; included by the modules that carry assertions.
`ifndef BITMAP_TO_LCD_PAGE_TRANSPOSE_CORE_MACROS_SVH
`define BITMAP_TO_LCD_PAGE_TRANSPOSE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BLTP_ASSERT_IMP(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("implication check failed");
`define BLTP_ASSERT_NXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("next-cycle check failed");
`else
`define BLTP_ASSERT_IMP(label, clk, rstn, cond, expr)
`define BLTP_ASSERT_NXT(label, clk, rstn, cond, expr)
`endif

`endif

/* rtl/bltp_pkg.sv */
// Shared constants and types for the bitmap to LCD page transpose core.
// No dependencies.
package bltp_pkg;

    localparam int WIDTH_PIXELS = 84;
    localparam int PAGE_COUNT   = 6;
    localparam int ROW_BYTES    = 12;

    localparam int BYTE_W  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int ROW_W   = 3;
    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W   = BYTE_W + 3;
    localparam int IDX_W   = 9;
    localparam int PROD_W  = PAGE_W + IDX_W;
    localparam int ACC_W   = 64;
    localparam int SPAN    = ROW_BYTES * 8;
    localparam int LAST_COLUMN = ((WIDTH_PIXELS < SPAN) ? WIDTH_PIXELS : SPAN) - 1;
    localparam int LAST_ROW = 7;

    // one page byte position handed to the emitter
    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [COL_W-1:0]  base_col;
        logic [COL_W-1:0]  last_col;
        logic [IDX_W-1:0]  page_base;
        logic              final_page;
    } emit_load_t;

    typedef struct packed {
        logic busy;
        logic last_beat;
    } emit_status_t;

endpackage

/* rtl/bitmap_to_lcd_page_transpose_core.sv */
// Top level of the bitmap to LCD page transpose core.
// Depends on bltp_pkg, bltp_ram, bltp_emitter and the assertion macro header.
//
//  channel   dir  tdata (low bit up)                    tlast     tuser
//  s_        in   bmp_byte[7:0]                         -         -
//  m_        out  screen_index[8:0], screen_byte[16:9]  run_last  frame_end
//
// Flow: s_tready stays high for a byte of rows one to seven or a padding byte. An
// eighth-row byte with n real columns gives n beats; the next such byte waits until
// the RAM read stage and the emitter are free again.
// Reset: counters clear synchronously; the page accumulator RAM is not cleared, as each
// row lane of an entry is rewritten within a page before the eighth row emits it.
// Stalls: s_tready drops for an eighth-row byte with real columns while the read stage
// or emitter is busy with an earlier one; m_tready low holds the emitter and such bytes.
`include "bitmap_to_lcd_page_transpose_core_macros.svh"
module bitmap_to_lcd_page_transpose_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // bmp_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // screen_index[8:0], screen_byte[16:9], zero [23:17]
    output logic        m_tlast,
    output logic [0:0]  m_tuser     // frame_end
);

    localparam int BW  = bltp_pkg::BYTE_W;
    localparam int AW  = bltp_pkg::ACC_W;

    // position counters
    logic [BW-1:0]               byte_reg, byte_next;
    logic [bltp_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [bltp_pkg::PAGE_W-1:0] pfb_reg, pfb_next;

    // read stage: the word whose RAM read is in flight
    logic                        p1_valid_reg;
    logic                        p1_emit_reg;
    logic [BW-1:0]               p1_addr_reg;
    logic [bltp_pkg::ROW_W-1:0]  p1_row_reg;
    logic [7:0]                  p1_data_reg;
    logic [bltp_pkg::PAGE_W-1:0] p1_pfb_reg;

    // last write, for read-during-write forwarding
    logic                        wr_valid_reg;
    logic [BW-1:0]               wr_addr_reg;
    logic [AW-1:0]               wr_data_reg;

    logic                        s_accept;
    logic                        in_has_cols;
    logic                        emit_ready;
    logic [AW-1:0]               ram_rdata;
    logic [AW-1:0]               acc_old;
    logic [AW-1:0]               acc_new;
    logic [bltp_pkg::COL_W-1:0]  base_col;
    logic [bltp_pkg::COL_W-1:0]  top_col;
    logic [bltp_pkg::PAGE_W-1:0] page_num;
    logic [bltp_pkg::PROD_W-1:0] page_prod;
    bltp_pkg::emit_load_t        load;
    bltp_pkg::emit_status_t      emit_status;

    // an eighth-row byte that covers at least one real column
    assign in_has_cols = (row_reg == bltp_pkg::ROW_W'(bltp_pkg::LAST_ROW))
                      && ({byte_reg, 3'b000} <= bltp_pkg::COL_W'(bltp_pkg::LAST_COLUMN));

    // emitter is free next cycle unless the read stage loads it now
    assign emit_ready = !emit_status.busy || (emit_status.last_beat && m_tready);
    assign s_tready   = !in_has_cols || (!(p1_valid_reg && p1_emit_reg) && emit_ready);
    assign s_accept   = s_tvalid && s_tready;

    bltp_ram #(
        .WIDTH (AW),
        .DEPTH (bltp_pkg::ROW_BYTES)
    ) u_acc_ram (
        .clk   (aclk),
        .we    (p1_valid_reg),
        .waddr (p1_addr_reg),
        .wdata (acc_new),
        .raddr (byte_reg),
        .rdata (ram_rdata)
    );

    // merge the new row into the accumulated page byte
    assign acc_old = (wr_valid_reg && wr_addr_reg == p1_addr_reg) ? wr_data_reg : ram_rdata;

    always_comb begin
        acc_new = acc_old;
        acc_new[int'(p1_row_reg)*8 +: 8] = p1_data_reg;
    end

    // emitter load fields
    assign base_col  = {p1_addr_reg, 3'b000};
    assign top_col   = (base_col + bltp_pkg::COL_W'(7)
                        > bltp_pkg::COL_W'(bltp_pkg::LAST_COLUMN))
                     ? bltp_pkg::COL_W'(bltp_pkg::LAST_COLUMN)
                     : base_col + bltp_pkg::COL_W'(7);
    assign page_num  = bltp_pkg::PAGE_W'(bltp_pkg::PAGE_COUNT - 1) - p1_pfb_reg;
    assign page_prod = bltp_pkg::PROD_W'(page_num)
                     * bltp_pkg::PROD_W'(bltp_pkg::WIDTH_PIXELS);

    assign load.acc        = acc_new;
    assign load.base_col   = base_col;
    assign load.last_col   = top_col;
    assign load.page_base  = page_prod[bltp_pkg::IDX_W-1:0];
    assign load.final_page = (p1_pfb_reg == bltp_pkg::PAGE_W'(bltp_pkg::PAGE_COUNT - 1));

    bltp_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (p1_valid_reg && p1_emit_reg),
        .load       (load),
        .status     (emit_status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // position counters advance per accepted word
    always_comb begin
        byte_next = byte_reg;
        row_next  = row_reg;
        pfb_next  = pfb_reg;
        if (s_accept) begin
            if (byte_reg == BW'(bltp_pkg::ROW_BYTES - 1)) begin
                byte_next = '0;
                if (row_reg == bltp_pkg::ROW_W'(bltp_pkg::LAST_ROW)) begin
                    row_next = '0;
                    if (pfb_reg == bltp_pkg::PAGE_W'(bltp_pkg::PAGE_COUNT - 1)) begin
                        pfb_next = '0;
                    end else begin
                        pfb_next = pfb_reg + 1'b1;
                    end
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                byte_next = byte_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg     <= '0;
            row_reg      <= '0;
            pfb_reg      <= '0;
            p1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else begin
            byte_reg     <= byte_next;
            row_reg      <= row_next;
            pfb_reg      <= pfb_next;
            p1_valid_reg <= s_accept;
            wr_valid_reg <= p1_valid_reg;
        end
        if (s_accept) begin
            p1_emit_reg <= in_has_cols;
            p1_addr_reg <= byte_reg;
            p1_row_reg  <= row_reg;
            p1_data_reg <= s_tdata;
            p1_pfb_reg  <= pfb_reg;
        end
        wr_addr_reg <= p1_addr_reg;
        wr_data_reg <= acc_new;
    end

    // an eighth-row word reaching the merge stage always finds the emitter free
    `BLTP_ASSERT_IMP(a_emit_free, aclk, aresetn, p1_valid_reg && p1_emit_reg, emit_ready)
    // the frame end column is always the last column of its input word
    `BLTP_ASSERT_IMP(a_frame_end_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    // the merge stage never addresses beyond the row
    `BLTP_ASSERT_IMP(a_addr_range, aclk, aresetn, p1_valid_reg,
                     p1_addr_reg <= BW'(bltp_pkg::ROW_BYTES - 1))
    // an accepted eighth-row word with columns loads the emitter next cycle
    `BLTP_ASSERT_NXT(a_load_follows, aclk, aresetn, s_accept && in_has_cols,
                     p1_valid_reg && p1_emit_reg)

endmodule

/* rtl/bltp_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bltp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bltp_emitter.sv */
// Column emitter: walks the columns of one accumulated page byte, one word per beat.
// Depends on bltp_pkg.
module bltp_emitter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load_valid,
    input  bltp_pkg::emit_load_t       load,
    output bltp_pkg::emit_status_t     status,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,
    output logic                       m_tlast,
    output logic [0:0]                 m_tuser
);

    logic                          busy_reg, busy_next;
    bltp_pkg::emit_load_t          cur_reg, cur_next;
    logic [bltp_pkg::COL_W-1:0]    col_reg, col_next;
    logic                          last_beat;
    logic [2:0]                    bit_sel;
    logic [7:0]                    screen_byte;
    logic [bltp_pkg::IDX_W-1:0]    screen_index;

    assign last_beat = (col_reg == cur_reg.last_col);
    assign bit_sel   = col_reg[2:0];

    always_comb begin
        for (int r = 0; r < 8; r++) begin
            screen_byte[7-r] = cur_reg.acc[r*8 + 7 - int'(bit_sel)];
        end
    end

    assign screen_index = cur_reg.page_base
                        + bltp_pkg::IDX_W'(col_reg);

    assign m_tvalid = busy_reg;
    assign m_tdata  = {7'd0, screen_byte, screen_index};
    assign m_tlast  = last_beat;
    assign m_tuser  = cur_reg.final_page
                    && (col_reg == bltp_pkg::COL_W'(bltp_pkg::LAST_COLUMN));

    assign status.busy      = busy_reg;
    assign status.last_beat = last_beat;

    always_comb begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        col_next  = col_reg;
        if (busy_reg && m_tready) begin
            if (last_beat) begin
                busy_next = 1'b0;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
        if (load_valid) begin
            busy_next = 1'b1;
            cur_next  = load;
            col_next  = load.base_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cur_reg <= cur_next;
        col_reg <= col_next;
    end

endmodule

/* sim/tb.sv */
// Self-checking testbench for bitmap_to_lcd_page_transpose_core.
// Depends on bltp_pkg and the core RTL; a built-in page transposer predicts every
// screen word, and a monitor checks each word leaving the m_ channel against it.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one expected screen word: tdata fields plus tlast and tuser
    typedef struct {
        logic [8:0] screen_index;
        logic [7:0] screen_byte;
        logic       run_last;
        logic       frame_end;
    } screen_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // bmp_byte[7:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // screen_index[8:0], screen_byte[16:9], zero [23:17]
    logic        m_tlast;     // run_last
    logic [0:0]  m_tuser;     // frame_end

    // transposer state kept alongside the core
    logic [63:0]  page_rows [bltp_pkg::ROW_BYTES];  // byte r of an entry = row r of the page
    int           byte_pos;
    int           row_pos;
    int           page_pos;               // page counted from the bottom

    screen_word_t screen_words_due[$];    // predicted words, oldest first
    int           mismatch_count;
    int           send_idle_pct;
    int           recv_idle_pct;

    bitmap_to_lcd_page_transpose_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Store one accepted bitmap byte into the page and, on the eighth row of a
    // page, queue the screen words its columns complete (padding columns skipped).
    task automatic transpose_byte(input logic [7:0] bmp_byte);
        logic [63:0]  acc;
        int           col;
        int           col_stop;
        int           screen_page;
        screen_word_t w;
        acc = page_rows[byte_pos];
        acc[row_pos*8 +: 8] = bmp_byte;
        page_rows[byte_pos] = acc;
        if (row_pos == bltp_pkg::LAST_ROW) begin
            screen_page = bltp_pkg::PAGE_COUNT - 1 - page_pos;
            // last column this byte emits: its own bit 0, or the image edge
            col_stop = (byte_pos*8 + 7 < bltp_pkg::LAST_COLUMN) ? byte_pos*8 + 7
                                                                : bltp_pkg::LAST_COLUMN;
            for (int b = 0; b < 8; b++) begin
                col = byte_pos*8 + b;
                if (col <= col_stop) begin
                    // row r of the page lands in bit 7-r; MSB of a bmp byte is column 0
                    for (int r = 0; r < 8; r++)
                        w.screen_byte[7-r] = acc[r*8 + 7 - b];
                    w.screen_index = 9'(screen_page*bltp_pkg::WIDTH_PIXELS + col);
                    w.run_last     = (col == col_stop);
                    w.frame_end    = (page_pos == bltp_pkg::PAGE_COUNT-1)
                                  && (col == bltp_pkg::LAST_COLUMN);
                    screen_words_due.push_back(w);
                end
            end
        end
        byte_pos++;
        if (byte_pos == bltp_pkg::ROW_BYTES) begin
            byte_pos = 0;
            if (row_pos == bltp_pkg::LAST_ROW) begin
                row_pos  = 0;
                page_pos = (page_pos == bltp_pkg::PAGE_COUNT-1) ? 0 : page_pos + 1;
            end else begin
                row_pos++;
            end
        end
    endtask

    // Present one word on s_, with a random gap first; returns in the step
    // right after the accepting edge so the next word can follow back to back.
    task automatic send_bmp_byte(input logic [7:0] bmp_byte);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bmp_byte;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        transpose_byte(bmp_byte);
    endtask

    // Sender holds off until every predicted word has left the core.
    task automatic wait_screen_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (screen_words_due.size() != 0);
    endtask

    function automatic void note_mismatch(input string what, input logic [8:0] want_idx,
                                          input logic [8:0] got_idx);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t: %s: expected index %0d, got index %0d (byte %h last %b end %b)",
                     $realtime, what, want_idx, got_idx, m_tdata[16:9], m_tlast, m_tuser[0]);
    endfunction

    // Receiver stalls at random, per the current idle setting.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Output checker: every accepted word against the oldest prediction.
    always @(posedge aclk) begin
        screen_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (screen_words_due.size() == 0) begin
                note_mismatch("unexpected word", 9'd0, m_tdata[8:0]);
            end else begin
                want = screen_words_due.pop_front();
                if (m_tdata[8:0] !== want.screen_index || m_tdata[16:9] !== want.screen_byte ||
                    m_tlast !== want.run_last || m_tuser[0] !== want.frame_end) begin
                    note_mismatch("word mismatch", want.screen_index, m_tdata[8:0]);
                    if (mismatch_count <= 10)
                        $display("    expected byte %h last %b end %b", want.screen_byte,
                                 want.run_last, want.frame_end);
                end
            end
        end
    end

    // One page with fixed rows: all ones, all zeros, alternating, single-bit and
    // ramp rows, then an eighth row of extreme values, a partly padded byte 10
    // (low nibble ignored) and a byte wholly in padding that must stay silent.
    task automatic test_directed_page();
        logic [7:0] row_fill [7] = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01, 8'h00};
        logic [7:0] last_row [bltp_pkg::ROW_BYTES] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hA5,
                                                       8'h5A, 8'h0F, 8'hF0, 8'h3C, 8'hC3,
                                                       8'hFF, 8'hFF};
        for (int r = 0; r < 7; r++)
            for (int b = 0; b < bltp_pkg::ROW_BYTES; b++)
                send_bmp_byte((r == 6) ? 8'(b * 8'h11) : row_fill[r]);
        for (int b = 0; b < bltp_pkg::ROW_BYTES; b++)
            send_bmp_byte(last_row[b]);
    endtask

    // Random pixel bytes, weighted toward solid black and white.
    task automatic test_random_stream(input int count, input int s_idle, input int m_idle);
        logic [7:0] v;
        send_idle_pct = s_idle;
        recv_idle_pct = m_idle;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: v = 8'h00;
                1: v = 8'hFF;
                default: v = 8'($urandom);
            endcase
            send_bmp_byte(v);
        end
    endtask

    initial begin
        s_tvalid       <= 1'b0;
        s_tdata        <= 8'h00;
        m_tready       <= 1'b0;
        aresetn        <= 1'b0;
        byte_pos       = 0;
        row_pos        = 0;
        page_pos       = 0;
        mismatch_count = 0;
        send_idle_pct  = 32;
        recv_idle_pct  = 74;
        foreach (page_rows[i]) page_rows[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed page plus three random stretches, one per idle pattern
        test_directed_page();
        test_random_stream(58, 32, 74);
        wait_screen_drained();
        test_random_stream(58, 74, 32);
        wait_screen_drained();
        test_random_stream(58, 0, 0);

        wait_screen_drained();
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && screen_words_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/bltp_pkg.sv
rtl/bltp_ram.sv
rtl/bltp_emitter.sv
rtl/bitmap_to_lcd_page_transpose_core.sv
sim/tb.sv
